@@ hw/rtl/deq_pkg.sv @@
// Shared types and constants for the double-ended queue.
package deq_pkg;

    // Default sizes handed to the top level
    localparam int DEF_DEPTH     = 16;
    localparam int DEF_WORD_BITS = 32;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_MATCH_MASK = 1'b0;  // register select, paddr[2]

    // Request action codes
    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_FIND       = 3'd4,
        ACT_CLEAR      = 3'd5
    } t_action;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    // What every cell of the chain does this cycle
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_RIGHT,
        CELL_SHIFT_LEFT,
        CELL_LOAD,
        CELL_ROTATE
    } t_cell_op;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIND,
        ST_OUT
    } t_state;

endpackage

@@ hw/rtl/deq_cell.sv @@
// One storage cell of the queue chain; cell k holds the k-th entry from the front.
module deq_cell #(
    parameter int DEPTH     = deq_pkg::DEF_DEPTH,
    parameter int WORD_BITS = deq_pkg::DEF_WORD_BITS,
    parameter int IDX       = 0
) (
    input  logic                         i_clk,
    input  deq_pkg::t_cell_op            i_op,
    input  logic [$clog2(DEPTH+1)-1:0]   i_count,
    input  logic [WORD_BITS-1:0]         i_push_word,
    input  logic [WORD_BITS-1:0]         i_left,   // neighbor toward the front
    input  logic [WORD_BITS-1:0]         i_right,  // neighbor toward the back
    input  logic [WORD_BITS-1:0]         i_wrap,   // front cell, for rotation
    output logic [WORD_BITS-1:0]         o_word
);
    import deq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] MY_POS  = CW'(IDX);
    localparam logic [CW-1:0] MY_NEXT = CW'(IDX + 1);

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;

    // Next word: shift, load at the back slot, or rotate among held entries
    always_comb begin
        n_word = r_word;
        case (i_op)
            CELL_SHIFT_RIGHT: n_word = i_left;
            CELL_SHIFT_LEFT:  n_word = i_right;
            CELL_LOAD: begin
                if (i_count == MY_POS) begin
                    n_word = i_push_word;
                end
            end
            CELL_ROTATE: begin
                if (MY_NEXT == i_count) begin
                    n_word = i_wrap;
                end else if (MY_NEXT < i_count) begin
                    n_word = i_right;
                end
            end
            default: n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

@@ hw/rtl/deq_ctrl.sv @@
// Queue controller: request decode, count tracking, find walk and result register.
module deq_ctrl #(
    parameter int DEPTH     = deq_pkg::DEF_DEPTH,
    parameter int WORD_BITS = deq_pkg::DEF_WORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request side
    input  logic                         i_req_valid,
    output logic                         o_req_ready,
    input  logic [2:0]                   i_action,
    input  logic [WORD_BITS-1:0]         i_data,
    input  logic [WORD_BITS-1:0]         i_mask,
    // chain side
    input  logic [WORD_BITS-1:0]         i_front,
    input  logic [WORD_BITS-1:0]         i_back,
    output deq_pkg::t_cell_op            o_cell_op,
    output logic [$clog2(DEPTH+1)-1:0]   o_count,
    output logic [$clog2(DEPTH)-1:0]     o_last,
    // result side
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output logic [1:0]                   o_status,
    output logic [WORD_BITS-1:0]         o_data,
    output logic [$clog2(DEPTH+1)-1:0]   o_entry_count,
    output logic [WORD_BITS-1:0]         o_front_word,
    output logic [WORD_BITS-1:0]         o_back_word,
    output logic                         o_is_empty
);
    import deq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count;
    logic [IW-1:0]         r_step;
    logic [WORD_BITS-1:0]  r_key;
    logic                  r_found;
    t_status               r_status;
    logic [WORD_BITS-1:0]  r_result;

    logic                  r_ovalid;
    t_status               r_o_status;
    logic [WORD_BITS-1:0]  r_o_data;
    logic [CW-1:0]         r_o_count;
    logic [WORD_BITS-1:0]  r_o_front;
    logic [WORD_BITS-1:0]  r_o_back;
    logic                  r_o_empty;

    logic accept;
    logic is_full;
    logic is_empty;
    logic front_match;
    logic out_free;
    logic [IW-1:0] last;

    assign accept   = i_req_valid && o_req_ready;
    assign is_full  = (r_count == FULL_COUNT);
    assign is_empty = (r_count == '0);
    assign last     = IW'(r_count - CW'(1));
    assign out_free = !r_ovalid || i_res_ready;
    assign front_match = (i_front != '0) && (((i_front ^ r_key) & i_mask) == '0);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_action == ACT_FIND && !is_empty) begin
                        n_state = ST_FIND;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_FIND: begin
                if (r_step == last) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs toward the request side and the chain
    always_comb begin
        o_req_ready = 1'b0;
        o_cell_op   = CELL_HOLD;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    case (i_action)
                        ACT_PUSH_FRONT: if (!is_full) o_cell_op = CELL_SHIFT_RIGHT;
                        ACT_PUSH_BACK:  if (!is_full) o_cell_op = CELL_LOAD;
                        ACT_POP_FRONT:  if (!is_empty) o_cell_op = CELL_SHIFT_LEFT;
                        default:        o_cell_op = CELL_HOLD;
                    endcase
                end
            end
            ST_FIND: o_cell_op = CELL_ROTATE;
            default: o_cell_op = CELL_HOLD;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                case (i_action)
                    ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                        if (!is_full) r_count <= r_count + CW'(1);
                    end
                    ACT_POP_FRONT, ACT_POP_BACK: begin
                        if (!is_empty) r_count <= r_count - CW'(1);
                    end
                    ACT_CLEAR: r_count <= '0;
                    default:   r_count <= r_count;
                endcase
            end
            if (r_state == ST_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_res_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Per-request status, result word and find walk
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key   <= i_data;
            r_found <= 1'b0;
            r_step  <= '0;
            case (i_action)
                ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                    r_status <= is_full ? STAT_FULL : STAT_OK;
                    r_result <= '0;
                end
                ACT_POP_FRONT: begin
                    r_status <= is_empty ? STAT_EMPTY : STAT_OK;
                    r_result <= is_empty ? '0 : i_front;
                end
                ACT_POP_BACK: begin
                    r_status <= is_empty ? STAT_EMPTY : STAT_OK;
                    r_result <= is_empty ? '0 : i_back;
                end
                ACT_FIND: begin
                    r_status <= STAT_NOT_FOUND;
                    r_result <= '0;
                end
                default: begin
                    r_status <= STAT_OK;
                    r_result <= '0;
                end
            endcase
        end else if (r_state == ST_FIND) begin
            r_step <= r_step + IW'(1);
            if (front_match && !r_found) begin
                r_found  <= 1'b1;
                r_status <= STAT_OK;
                r_result <= i_front;
            end
        end
    end

    // Result register, loaded once the chain has settled
    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            r_o_status <= r_status;
            r_o_data   <= r_result;
            r_o_count  <= r_count;
            r_o_front  <= is_empty ? '0 : i_front;
            r_o_back   <= is_empty ? '0 : i_back;
            r_o_empty  <= is_empty;
        end
    end

    assign o_count       = r_count;
    assign o_last        = last;
    assign o_res_valid   = r_ovalid;
    assign o_status      = r_o_status;
    assign o_data        = r_o_data;
    assign o_entry_count = r_o_count;
    assign o_front_word  = r_o_front;
    assign o_back_word   = r_o_back;
    assign o_is_empty    = r_o_empty;

endmodule

@@ hw/rtl/double_ended_queue.sv @@
// Push, pop, clear: an accepted request goes to ST_OUT, then its result is registered.
// Find on a non-empty queue goes through ST_FIND first, where the chain rotates once
// through all held entries, one per cycle, before the result is registered in ST_OUT.
// One request is in flight at a time; s_axis_tready is high only while idle.
// The result register frees the request side once a result is taken or not yet pending.
// Synchronous active-low reset empties the queue and sets match_mask bits [MW-1:0] to ones.
module double_ended_queue #(
    parameter int DEPTH     = deq_pkg::DEF_DEPTH,
    parameter int WORD_BITS = deq_pkg::DEF_WORD_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // request stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // action[2:0], data_in[WORD_BITS+2:3], zero pad
    input  logic [((3+WORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    // result stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // status[1:0], data_out, entry_count, front_word, back_word, is_empty, zero pad
    output logic [((3*WORD_BITS+$clog2(DEPTH+1)+3+7)/8)*8-1:0] m_axis_tdata,
    // configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [deq_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [deq_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [deq_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready
);
    import deq_pkg::*;

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int IW  = $clog2(DEPTH);
    localparam int MW  = (WORD_BITS < APB_DATA_W) ? WORD_BITS : APB_DATA_W;
    localparam int OB  = 3 * WORD_BITS + CW + 3;
    localparam logic [WORD_BITS-1:0] MASK_RESET = WORD_BITS'({MW{1'b1}});

    // Match mask register
    logic [WORD_BITS-1:0] r_mask;
    logic [WORD_BITS-1:0] n_mask;
    logic                 cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_MATCH_MASK);

    always_comb begin
        n_mask = '0;
        n_mask[MW-1:0] = pwdata[MW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= MASK_RESET;
        end else if (cfg_write) begin
            r_mask <= n_mask;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MATCH_MASK) begin
            prdata[MW-1:0] = r_mask[MW-1:0];
        end
    end

    // Controller
    t_cell_op              cell_op;
    logic [CW-1:0]         count;
    logic [IW-1:0]         last;
    logic [WORD_BITS-1:0]  push_word;
    logic [WORD_BITS-1:0]  words [DEPTH];
    logic [WORD_BITS-1:0]  back_word;

    logic [1:0]            res_status;
    logic [WORD_BITS-1:0]  res_data;
    logic [CW-1:0]         res_count;
    logic [WORD_BITS-1:0]  res_front;
    logic [WORD_BITS-1:0]  res_back;
    logic                  res_empty;

    assign push_word = s_axis_tdata[WORD_BITS+2:3];
    assign back_word = words[last];

    deq_ctrl #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (s_axis_tvalid),
        .o_req_ready   (s_axis_tready),
        .i_action      (s_axis_tdata[2:0]),
        .i_data        (push_word),
        .i_mask        (r_mask),
        .i_front       (words[0]),
        .i_back        (back_word),
        .o_cell_op     (cell_op),
        .o_count       (count),
        .o_last        (last),
        .o_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .o_status      (res_status),
        .o_data        (res_data),
        .o_entry_count (res_count),
        .o_front_word  (res_front),
        .o_back_word   (res_back),
        .o_is_empty    (res_empty)
    );

    // Chain of cells, front at index zero
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_BITS-1:0] left_word;
        logic [WORD_BITS-1:0] right_word;

        if (g == 0) begin : g_first
            assign left_word = push_word;
        end else begin : g_mid
            assign left_word = words[g-1];
        end

        if (g == DEPTH - 1) begin : g_end
            assign right_word = words[g];
        end else begin : g_inner
            assign right_word = words[g+1];
        end

        deq_cell #(
            .DEPTH     (DEPTH),
            .WORD_BITS (WORD_BITS),
            .IDX       (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_op        (cell_op),
            .i_count     (count),
            .i_push_word (push_word),
            .i_left      (left_word),
            .i_right     (right_word),
            .i_wrap      (words[0]),
            .o_word      (words[g])
        );
    end

    // Pack the result fields
    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[OB-1:0] = {res_empty, res_back, res_front, res_count,
                                res_data, res_status};
    end

endmodule
